// ----- hw/rtl/sfr_pkg.sv -----
// shared constants and types for the serial frame receiver
`timescale 1ns / 1ps

package sfr_pkg;

    localparam int MAX_PAYLOAD = 30;
    localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
    localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int BYTE_W      = 8;
    localparam int POS_W       = 5;
    localparam int LEN_W       = 16;

    localparam logic [BYTE_W-1:0] HEADER_BYTE    = 8'hC5;
    localparam logic [LEN_W-1:0]  MIN_FRAME_LEN  = 16'd7;
    localparam logic [LEN_W-1:0]  MAX_FRAME_LEN  = LEN_W'(MAX_PAYLOAD) + MIN_FRAME_LEN;
    localparam logic [LEN_W-1:0]  FRAME_OVERHEAD = 16'd5;

    typedef struct packed {
        logic              start;
        logic [BYTE_W-1:0] command;
        logic [CNT_W-1:0]  count;
    } t_drain_req;

endpackage

// ----- hw/rtl/serial_frame_receiver.sv -----
// top level of the serial frame receiver
`timescale 1ns / 1ps

// Input channel: one received byte per request on i_rx_byte, handshake
// i_in_valid / o_in_ready. Frames are 0xC5, length low, length high, command,
// length minus 5 payload bytes, then an 8-bit additive checksum of all bytes
// before it. Bad lengths, payload overflow and checksum mismatch drop the frame.
// Output channel: one request per payload byte of a good frame, handshake
// o_out_valid / i_out_ready, carrying command, byte, position and last flag.
// Throughput: one input byte per cycle while parsing. Payload bytes sit in a
// registered-read ram; after a matching checksum the drain reads it one entry
// a cycle and emits one result per cycle while the receiver is ready; the read
// of entry 0 is issued with the checksum byte and goes through the ram read
// register into the output register. o_in_ready is low while the drain runs; the
// final result may still wait in the output register while new bytes are taken.
// A stalled receiver holds the output register and the drain waits with it.
// Reset (synchronous, active low) returns the parser to header search and
// empties the output register; the ram itself is not cleared.

module serial_frame_receiver (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [sfr_pkg::BYTE_W-1:0]    i_rx_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [sfr_pkg::BYTE_W-1:0]    o_command,
    output logic [sfr_pkg::BYTE_W-1:0]    o_payload_byte,
    output logic [sfr_pkg::POS_W-1:0]     o_payload_position,
    output logic                          o_last
);

    logic                          accept;
    logic                          busy;
    logic                          wr_en;
    logic [sfr_pkg::ADDR_W-1:0]    wr_addr;
    logic [sfr_pkg::BYTE_W-1:0]    wr_data;
    logic                          rd_en;
    logic [sfr_pkg::ADDR_W-1:0]    rd_addr;
    logic [sfr_pkg::BYTE_W-1:0]    rd_data;
    sfr_pkg::t_drain_req           drain;

    assign o_in_ready = !busy;
    assign accept     = i_in_valid && !busy;

    sfr_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_rx_byte (i_rx_byte),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_drain   (drain)
    );

    sfr_ram #(
        .WIDTH (sfr_pkg::BYTE_W),
        .DEPTH (sfr_pkg::MAX_PAYLOAD)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    sfr_drain u_drain (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_drain            (drain),
        .i_rd_data          (rd_data),
        .o_rd_en            (rd_en),
        .o_rd_addr          (rd_addr),
        .o_busy             (busy),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_command          (o_command),
        .o_payload_byte     (o_payload_byte),
        .o_payload_position (o_payload_position),
        .o_last             (o_last)
    );

endmodule

// ----- hw/rtl/sfr_ram.sv -----
// generic single-port-write, registered-read ram
`timescale 1ns / 1ps

module sfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 30
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/sfr_parser.sv -----
// frame parser: header, length, command, payload write and checksum check
`timescale 1ns / 1ps

module sfr_parser (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  logic [sfr_pkg::BYTE_W-1:0]        i_rx_byte,
    output logic                              o_wr_en,
    output logic [sfr_pkg::ADDR_W-1:0]        o_wr_addr,
    output logic [sfr_pkg::BYTE_W-1:0]        o_wr_data,
    output sfr_pkg::t_drain_req               o_drain
);

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_LEN_LO  = 3'd1,
        PH_LEN_HI  = 3'd2,
        PH_CMD     = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CHECK   = 3'd5
    } t_phase;

    t_phase                         r_phase, n_phase;
    logic [sfr_pkg::BYTE_W-1:0]     r_sum, n_sum;
    logic [sfr_pkg::LEN_W-1:0]      r_len, n_len;
    logic [sfr_pkg::BYTE_W-1:0]     r_cmd, n_cmd;
    logic [sfr_pkg::CNT_W-1:0]      r_fill, n_fill;
    logic [sfr_pkg::LEN_W-1:0]      len_full;

    assign len_full  = {i_rx_byte, r_len[7:0]};
    assign o_wr_addr = r_fill[sfr_pkg::ADDR_W-1:0];
    assign o_wr_data = i_rx_byte;

    always_comb begin
        n_phase         = r_phase;
        n_sum           = r_sum;
        n_len           = r_len;
        n_cmd           = r_cmd;
        n_fill          = r_fill;
        o_wr_en         = 1'b0;
        o_drain.start   = 1'b0;
        o_drain.command = r_cmd;
        o_drain.count   = r_fill;
        if (i_accept) begin
            unique case (r_phase)
                PH_LEN_LO: begin
                    n_len   = {8'h00, i_rx_byte};
                    n_sum   = r_sum + i_rx_byte;
                    n_phase = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    n_len = len_full;
                    n_sum = r_sum + i_rx_byte;
                    if (len_full < sfr_pkg::MIN_FRAME_LEN ||
                        len_full > sfr_pkg::MAX_FRAME_LEN) begin
                        n_phase = PH_HEADER;
                    end else begin
                        n_phase = PH_CMD;
                    end
                end
                PH_CMD: begin
                    n_cmd   = i_rx_byte;
                    n_sum   = r_sum + i_rx_byte;
                    n_fill  = '0;
                    n_phase = PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    if (r_fill >= sfr_pkg::CNT_W'(sfr_pkg::MAX_PAYLOAD)) begin
                        n_fill  = '0;
                        n_phase = PH_HEADER;
                    end else begin
                        o_wr_en = 1'b1;
                        n_fill  = r_fill + 1'b1;
                        n_sum   = r_sum + i_rx_byte;
                        if (sfr_pkg::LEN_W'(r_fill) + sfr_pkg::FRAME_OVERHEAD + 16'd1
                            >= r_len) begin
                            n_phase = PH_CHECK;
                        end
                    end
                end
                PH_CHECK: begin
                    n_phase = PH_HEADER;
                    if (r_sum == i_rx_byte) begin
                        o_drain.start = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_HEADER;
                    if (i_rx_byte == sfr_pkg::HEADER_BYTE) begin
                        n_sum   = i_rx_byte;
                        n_phase = PH_LEN_LO;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_sum   <= '0;
            r_len   <= '0;
            r_cmd   <= '0;
            r_fill  <= '0;
        end else begin
            r_phase <= n_phase;
            r_sum   <= n_sum;
            r_len   <= n_len;
            r_cmd   <= n_cmd;
            r_fill  <= n_fill;
        end
    end

endmodule

// ----- hw/rtl/sfr_drain.sv -----
// payload drain: reads stored bytes and drives the result register
`timescale 1ns / 1ps

module sfr_drain (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sfr_pkg::t_drain_req           i_drain,
    input  logic [sfr_pkg::BYTE_W-1:0]    i_rd_data,
    output logic                          o_rd_en,
    output logic [sfr_pkg::ADDR_W-1:0]    o_rd_addr,
    output logic                          o_busy,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [sfr_pkg::BYTE_W-1:0]    o_command,
    output logic [sfr_pkg::BYTE_W-1:0]    o_payload_byte,
    output logic [sfr_pkg::POS_W-1:0]     o_payload_position,
    output logic                          o_last
);

    typedef enum logic {
        DR_IDLE,
        DR_EMIT
    } t_drain_state;

    t_drain_state                   r_state;
    logic [sfr_pkg::ADDR_W-1:0]     r_idx;
    logic [sfr_pkg::CNT_W-1:0]      r_cnt;
    logic [sfr_pkg::BYTE_W-1:0]     r_cmd;
    logic                           r_out_valid;
    logic [sfr_pkg::BYTE_W-1:0]     r_out_cmd;
    logic [sfr_pkg::BYTE_W-1:0]     r_out_byte;
    logic [sfr_pkg::POS_W-1:0]      r_out_pos;
    logic                           r_out_last;
    logic                           load;
    logic                           is_last;

    assign load    = (r_state == DR_EMIT) && (!r_out_valid || i_out_ready);
    assign is_last = (sfr_pkg::CNT_W'(r_idx) + 1'b1) == r_cnt;
    assign o_rd_en = i_drain.start || (load && !is_last);
    assign o_rd_addr = i_drain.start ? '0 : r_idx + 1'b1;
    assign o_busy  = (r_state == DR_EMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= DR_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                DR_IDLE: begin
                    if (i_drain.start) begin
                        r_state <= DR_EMIT;
                    end
                end
                DR_EMIT: begin
                    if (load && is_last) begin
                        r_state <= DR_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_drain.start) begin
            r_idx <= '0;
            r_cnt <= i_drain.count;
            r_cmd <= i_drain.command;
        end else if (load && !is_last) begin
            r_idx <= r_idx + 1'b1;
        end
        if (load) begin
            r_out_cmd  <= r_cmd;
            r_out_byte <= i_rd_data;
            r_out_pos  <= sfr_pkg::POS_W'(r_idx);
            r_out_last <= is_last;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_command          = r_out_cmd;
    assign o_payload_byte     = r_out_byte;
    assign o_payload_position = r_out_pos;
    assign o_last             = r_out_last;

endmodule
